// File: design/kvre_pkg.sv
`timescale 1ns / 1ps
package kvre_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_MAX  = 16;
  localparam int VAL_MAX  = 32;
  localparam int LINE_MAX = 128;
  localparam int RES_MAX  = 32;

  localparam int LA_W = $clog2(LINE_MAX);        // line store address
  localparam int LL_W = $clog2(LINE_MAX + 2);    // line length, saturates at LINE_MAX+1
  localparam int EI_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int EC_W = $clog2(ENTRIES + 1);
  localparam int KI_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int KL_W = $clog2(KEY_MAX + 1);
  localparam int VI_W = (VAL_MAX > 1) ? $clog2(VAL_MAX) : 1;
  localparam int VL_W = $clog2(VAL_MAX + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_KEY_BAD   = 4'd1,
    ST_KEY_EMPTY = 4'd2,
    ST_KEY_LONG  = 4'd3,
    ST_VAL_LONG  = 4'd4,
    ST_NOT_FOUND = 4'd5,
    ST_KEY_EXIST = 4'd6,
    ST_FULL      = 4'd7,
    ST_LINE_LONG = 4'd8
  } status_t;

  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] error_position;
    logic [7:0] value_char;
    logic       value_valid;
    logic       last_result;
  } res_t;

  function automatic logic is_key_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

// File: design/keyed_value_registry_engine.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake            | Beat
// ----------+-----------+----------------------+------------------------------
// command   | in        | start & !busy        | cmd (kind, char_code, last)
// cfg       | in        | cfg_valid & cfg_ready| cfg_data (allow_update)
// result    | out       | result_strobe        | result (one cycle, no stall)
//
// A character that is not last is stored, then the engine returns to idle.
// A last character runs a sequencer on the single line-store read port: it
// steps over each leading space, stripped CR/LF and key character, then walks
// the table entries, comparing key characters, then copies key and value
// characters into the stores, or streams value characters out as results.
// Reset is synchronous and clears the line length, entry count and sequencer;
// the stores need no clearing.
// Results cannot be stalled: each is driven for one cycle with result_strobe.
module keyed_value_registry_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  kvre_pkg::cmd_t  cmd,
  output logic            busy,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_data,
  output logic            result_strobe,
  output kvre_pkg::res_t  result
);
  import kvre_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_STORE  = 13'b0000000000010,
    S_LEAD   = 13'b0000000000100,
    S_TRIM   = 13'b0000000001000,
    S_KEY    = 13'b0000000010000,
    S_ENTRY  = 13'b0000000100000,
    S_CMPK   = 13'b0000001000000,
    S_CMPL   = 13'b0000010000000,
    S_DECIDE = 13'b0000100000000,
    S_KCOPY  = 13'b0001000000000,
    S_VCOPY  = 13'b0010000000000,
    S_STREAM = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } state_t;

  state_t state;

  logic [7:0] line_mem [LINE_MAX];
  logic [7:0] key_mem  [ENTRIES*KEY_MAX];
  logic [7:0] val_mem  [ENTRIES*VAL_MAX];
  logic [KL_W-1:0] key_len [ENTRIES];
  logic [VL_W-1:0] val_len [ENTRIES];

  logic            allow_update;
  logic [LL_W-1:0] line_length;
  logic [EC_W-1:0] entry_count;
  logic            kind;

  // parse registers
  logic [LL_W-1:0] p, endp, ks, vs;
  logic [KL_W-1:0] kl;
  logic [VL_W-1:0] vl;
  logic [1:0]      trim_n;
  logic            lead_done;

  // search / copy registers
  logic [EI_W-1:0] ent;
  logic [EC_W-1:0] ent_cnt;
  logic            found;
  logic [KL_W-1:0] ci;
  logic [LA_W:0]   li;         // line index for copy
  logic [7:0]      rd;         // registered line read
  logic [7:0]      krd;        // registered key read
  logic [7:0]      vrd;
  logic [VL_W-1:0] vi;
  logic [VL_W-1:0] stream_n;

  logic [3:0] st_r;
  logic [7:0] pos_r;

  // single line-store read address
  logic [LA_W-1:0] raddr;
  logic [LL_W-1:0] raddr_w;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_update <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      allow_update <= cfg_data;
    end
  end

  always_comb begin
    raddr_w = p;
    case (state)
      S_TRIM:  raddr_w = endp - LL_W'(1);
      S_CMPK:  raddr_w = ks + LL_W'(ci);
      S_KCOPY, S_VCOPY: raddr_w = LL_W'(li);
      default: raddr_w = p;
    endcase
    raddr = raddr_w[LA_W-1:0];
  end

  // stores: reads registered
  always_ff @(posedge clk) begin
    rd  <= line_mem[raddr];
    krd <= key_mem[{ent, ci[KI_W-1:0]}];
    vrd <= val_mem[{ent, vi[VI_W-1:0]}];
  end

  logic key_we, val_we;
  logic [EI_W-1:0] wr_ent;
  always_ff @(posedge clk) begin
    if (start && !busy && line_length < LL_W'(LINE_MAX)) begin
      line_mem[line_length[LA_W-1:0]] <= cmd.char_code;
    end
    if (key_we) key_mem[{wr_ent, ci[KI_W-1:0]}] <= rd;
    if (val_we) val_mem[{wr_ent, vi[VI_W-1:0]}] <= rd;
  end

  assign wr_ent = found ? ent : entry_count[EI_W-1:0];
  // copies lag the registered read: write when the previous read landed
  logic copy_live;
  assign key_we = (state == S_KCOPY) && copy_live;
  assign val_we = (state == S_VCOPY) && copy_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
      state         <= S_IDLE;
      line_length   <= '0;
      entry_count   <= '0;
    end else begin
      // strobe a beat from the emit state or a landed stream read
      result_strobe <= (state == S_EMIT) || (state == S_STREAM && lead_done);
      case (state)
        S_IDLE: begin
          if (start) begin
            kind <= cmd.kind;
            if (line_length <= LL_W'(LINE_MAX)) line_length <= line_length + LL_W'(1);
            if (cmd.last) begin
              endp      <= (line_length <= LL_W'(LINE_MAX)) ? line_length + LL_W'(1)
                                                            : line_length;
              p         <= '0;
              lead_done <= 1'b0;
              state     <= S_LEAD;
            end else begin
              state <= S_STORE;
            end
          end
        end
        S_STORE: state <= S_IDLE;
        // skip leading spaces, one char at a time, waiting for the registered read rd of p
        S_LEAD: begin
          line_length <= '0;
          if (endp > LL_W'(LINE_MAX)) begin
            st_r <= ST_LINE_LONG; pos_r <= 8'(LINE_MAX + 1); state <= S_EMIT;
          end else if (!lead_done) begin
            lead_done <= 1'b1;
          end else if (p < endp && rd == CH_SPACE) begin
            p <= p + LL_W'(1); lead_done <= 1'b0;
          end else begin
            trim_n <= 2'd0; lead_done <= 1'b0; state <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (!lead_done) begin
            lead_done <= 1'b1;
          end else if (trim_n != 2'd2 && endp > p && (rd == CH_LF || rd == CH_CR)) begin
            endp <= endp - LL_W'(1); trim_n <= trim_n + 2'd1; lead_done <= 1'b0;
          end else begin
            ks <= p; kl <= '0; lead_done <= 1'b0; state <= S_KEY;
          end
        end
        S_KEY: begin
          if (!lead_done) begin
            lead_done <= 1'b1;
          end else if (p >= endp) begin
            if (kl == '0) begin
              st_r <= ST_KEY_EMPTY; pos_r <= 8'(p + LL_W'(1)); state <= S_EMIT;
            end else begin
              vs <= p; vl <= '0;
              ent <= '0; ent_cnt <= '0; found <= 1'b0; state <= S_ENTRY;
            end
          end else if (is_key_char(rd)) begin
            if (kl == KL_W'(KEY_MAX)) begin
              st_r <= ST_KEY_LONG; pos_r <= 8'(p + LL_W'(1)); state <= S_EMIT;
            end else begin
              kl <= kl + KL_W'(1); p <= p + LL_W'(1); lead_done <= 1'b0;
            end
          end else if (rd == CH_SPACE) begin
            if ((endp - p - LL_W'(1)) > LL_W'(VAL_MAX)) begin
              st_r  <= ST_VAL_LONG;
              pos_r <= 8'(p + LL_W'(VAL_MAX + 2));
              state <= S_EMIT;
            end else begin
              vs <= p + LL_W'(1);
              vl <= VL_W'(endp - p - LL_W'(1));
              ent <= '0; ent_cnt <= '0; found <= 1'b0; state <= S_ENTRY;
            end
          end else begin
            st_r <= ST_KEY_BAD; pos_r <= 8'(p + LL_W'(1)); state <= S_EMIT;
          end
        end
        // walk table entries
        S_ENTRY: begin
          if (ent_cnt >= entry_count) begin
            state <= S_DECIDE;
          end else if (key_len[ent] == kl) begin
            ci <= '0; lead_done <= 1'b0; state <= S_CMPK;
          end else begin
            ent <= ent + EI_W'(1); ent_cnt <= ent_cnt + EC_W'(1);
          end
        end
        S_CMPK: begin
          if (ci == kl) begin
            found <= 1'b1; state <= S_DECIDE;
          end else if (!lead_done) begin
            lead_done <= 1'b1;
          end else begin
            lead_done <= 1'b0; state <= S_CMPL;
          end
        end
        S_CMPL: begin
          if (rd == krd) begin
            ci <= ci + KL_W'(1); state <= S_CMPK;
          end else begin
            ent <= ent + EI_W'(1); ent_cnt <= ent_cnt + EC_W'(1); state <= S_ENTRY;
          end
        end
        S_DECIDE: begin
          pos_r <= '0;
          if (kind == KIND_GET) begin
            if (!found) begin
              st_r <= ST_NOT_FOUND; state <= S_EMIT;
            end else if (val_len[ent] == '0) begin
              st_r <= ST_OK; state <= S_EMIT;
            end else begin
              stream_n  <= (val_len[ent] > VL_W'(RES_MAX)) ? VL_W'(RES_MAX) : val_len[ent];
              vi <= '0; lead_done <= 1'b0; state <= S_STREAM;
            end
          end else if (found) begin
            if (!allow_update) begin
              st_r <= ST_KEY_EXIST; state <= S_EMIT;
            end else begin
              vi <= '0; li <= (LA_W+1)'(vs); copy_live <= 1'b0; state <= S_VCOPY;
            end
          end else if (entry_count >= EC_W'(ENTRIES)) begin
            st_r <= ST_FULL; state <= S_EMIT;
          end else begin
            ci <= '0; li <= (LA_W+1)'(ks); copy_live <= 1'b0; state <= S_KCOPY;
          end
        end
        S_KCOPY: begin
          if (copy_live) ci <= ci + KL_W'(1);
          if (copy_live && ci + KL_W'(1) == kl) begin
            key_len[entry_count[EI_W-1:0]] <= kl;
            vi <= '0; li <= (LA_W+1)'(vs); copy_live <= 1'b0; state <= S_VCOPY;
          end else begin
            copy_live <= 1'b1; li <= li + (LA_W+1)'(1);
          end
        end
        S_VCOPY: begin
          if (copy_live) vi <= vi + VL_W'(1);
          if ((copy_live && vi + VL_W'(1) == vl) || vl == '0) begin
            val_len[wr_ent] <= vl;
            if (!found) entry_count <= entry_count + EC_W'(1);
            st_r <= ST_OK; pos_r <= '0; state <= S_EMIT;
          end else begin
            copy_live <= 1'b1; li <= li + (LA_W+1)'(1);
          end
        end
        // stream value characters, each once its registered value-store read has landed
        S_STREAM: begin
          if (!lead_done) begin
            lead_done <= 1'b1;
          end else begin
            result.status         <= ST_OK;
            result.error_position <= '0;
            result.value_char     <= vrd;
            result.value_valid    <= 1'b1;
            result.last_result    <= (vi + VL_W'(1) == stream_n);
            lead_done             <= 1'b0;
            vi <= vi + VL_W'(1);
            if (vi + VL_W'(1) == stream_n) state <= S_IDLE;
          end
        end
        S_EMIT: begin
          result.status         <= st_r;
          result.error_position <= pos_r;
          result.value_char     <= '0;
          result.value_valid    <= 1'b0;
          result.last_result    <= 1'b1;
          state                 <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
